/* rtl/core/assert_macros.svh */
// Assertion macros used by the responder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/icer_pkg.sv */
// Shared constants, types and status codes of the ICMP echo responder.
`timescale 1ns / 1ps
package icer_pkg;

  localparam int FRAME_WORDS = 64;
  localparam int ADDR_W      = $clog2(FRAME_WORDS);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int LEN_W       = ADDR_W + 4;
  localparam int ACC_W       = 16 + ADDR_W;
  localparam int SUM_W       = ACC_W + 2;
  localparam int LANES       = 4;
  localparam int HDR_WORDS   = 5;
  localparam int HDR_IDX_W   = 3;

  localparam logic [3:0] ST_REPLY      = 4'd0;
  localparam logic [3:0] ST_SHORT      = 4'd1;
  localparam logic [3:0] ST_NOT_IPV4   = 4'd2;
  localparam logic [3:0] ST_BAD_IHL    = 4'd3;
  localparam logic [3:0] ST_SHORT_ICMP = 4'd4;
  localparam logic [3:0] ST_NOT_ICMP   = 4'd5;
  localparam logic [3:0] ST_WRONG_ADDR = 4'd6;
  localparam logic [3:0] ST_NOT_ECHO   = 4'd7;
  localparam logic [3:0] ST_LEN_BAD    = 4'd8;

  localparam logic [LEN_W-1:0] POS_IP_START   = LEN_W'(14);
  localparam logic [LEN_W-1:0] POS_IP_CSUM    = LEN_W'(24);
  localparam logic [LEN_W-1:0] POS_IP_CSUM_LO = LEN_W'(25);
  localparam logic [LEN_W-1:0] MIN_FRAME      = LEN_W'(34);
  localparam logic [LEN_W-1:0] MIN_ICMP_OFS   = LEN_W'(22);
  localparam logic [LEN_W-1:0] CSUM_OFS       = LEN_W'(2);
  localparam logic [LEN_W-1:0] CSUM_OFS_LO    = LEN_W'(3);
  localparam logic [5:0]       MIN_IHL_BYTES  = 6'd20;
  localparam logic [15:0]      ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]       PROTO_ICMP     = 8'd1;
  localparam logic [7:0]       ICMP_ECHO_REQ  = 8'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SUM,
    S_DECIDE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             clr;
    logic             en;
    logic [LEN_W-1:0] icmp_start;
    logic [16:0]      icmp_end;
  } lane_ctrl_t;

  typedef struct packed {
    logic [ACC_W-1:0] icmp;
    logic [ACC_W-1:0] ip;
  } lane_sum_t;

endpackage

/* rtl/core/icmp_echo_responder_core.sv */
// Top level of the ICMP echo responder: frame store, checks and reply replay.
//
//  Channel   Ports                                            Handshake
//  input     word_data word_bytes word_last                   start && !busy
//  result    out_data out_bytes out_last frame_status         out_valid strobe
//  config    cfg_wr_data                                      cfg_wr_en
//
// An input beat is accepted whenever start is high and busy is low. After the
// last beat the block is busy to scan the stored words through the four
// checksum lanes, then to replay the reply, one beat per cycle; the single
// port of the frame memory paces both passes. A drop gives one beat. Reset
// is synchronous and clears all control state. Results are never stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module icmp_echo_responder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] word_data,
  input  logic [3:0]  word_bytes,
  input  logic        word_last,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output logic        out_valid,
  output logic [63:0] out_data,
  output logic [3:0]  out_bytes,
  output logic        out_last,
  output logic [3:0]  frame_status
);
  import icer_pkg::*;

  state_t state, state_next;

  logic [31:0]       local_ip;
  logic [63:0]       mem [FRAME_WORDS];
  logic [63:0]       hdr [HDR_WORDS];
  logic [63:0]       hsw [HDR_WORDS];
  logic [CNT_W-1:0]  word_count;
  logic [LEN_W-1:0]  byte_total;
  logic              overflow_flag;
  logic [LEN_W-1:0]  len;
  logic              ovf;
  logic [CNT_W-1:0]  wcnt;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  iss_k;
  logic              iss_valid;
  logic [63:0]       rd_data;
  logic [7:0]        icmp_type;

  logic              accept, frame_end, store_ok, issue, lane_en, merge_load, out_load;
  logic [3:0]        nb;
  logic [LEN_W-1:0]  bt_next;
  logic [CNT_W-1:0]  words_out;
  logic [LEN_W:0]    len_round;

  logic [15:0]       ether, tot;
  logic [5:0]        hl;
  logic [7:0]        proto;
  logic [31:0]       dst;
  logic [LEN_W-1:0]  icmp_start;
  logic [3:0]        status;
  logic [15:0]       csum_icmp, csum_ip;

  logic [63:0]       base, reply;
  logic              reply_last;
  logic [3:0]        reply_bytes;
  logic [LEN_W-1:0]  bpos;

  lane_ctrl_t        lctrl;
  lane_sum_t         lsum [LANES];

  assign accept    = start && !busy;
  assign frame_end = accept && word_last;
  assign nb        = (word_bytes > 4'd8) ? 4'd8 : word_bytes;
  assign store_ok  = word_count < CNT_W'(FRAME_WORDS);
  assign bt_next   = byte_total + (word_last ? LEN_W'(nb) : LEN_W'(8));
  assign len_round = {1'b0, len} + (LEN_W + 1)'(7);
  assign words_out = len_round[CNT_W+2:3];

  assign ether      = hdr[1][31:16];
  assign hl         = {hdr[1][11:8], 2'b00};
  assign tot        = hdr[2][63:48];
  assign proto      = hdr[2][7:0];
  assign dst        = {hdr[3][15:0], hdr[4][63:48]};
  assign icmp_start = POS_IP_START + LEN_W'(hl);

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip <= '0;
    end else if (cfg_wr_en) begin
      local_ip <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count    <= '0;
      byte_total    <= '0;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      if (word_last) begin
        word_count    <= '0;
        byte_total    <= '0;
        overflow_flag <= 1'b0;
      end else if (store_ok) begin
        word_count <= word_count + CNT_W'(1);
        byte_total <= bt_next;
      end else begin
        overflow_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      len  <= store_ok ? bt_next : byte_total;
      ovf  <= overflow_flag || !store_ok;
      wcnt <= store_ok ? word_count + CNT_W'(1) : word_count;
    end
    if (accept && store_ok) begin
      mem[word_count[ADDR_W-1:0]] <= word_data;
    end
    if (accept && word_count < CNT_W'(HDR_WORDS)) begin
      hdr[word_count[HDR_IDX_W-1:0]] <= word_data;
    end
    if (issue) begin
      rd_data <= mem[k[ADDR_W-1:0]];
    end
    iss_k <= k;
    if (state == S_SCAN && iss_valid && iss_k == icmp_start[LEN_W-1:3]) begin
      icmp_type <= rd_data[{~icmp_start[2:0], 3'b000} +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iss_valid <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      state     <= state_next;
      iss_valid <= issue;
      out_valid <= out_load;
      if (frame_end || state == S_DECIDE) begin
        k <= '0;
      end else if (issue) begin
        k <= k + CNT_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (frame_end) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (k == wcnt && !iss_valid) state_next = S_SUM;
      end
      S_SUM: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = (status == ST_REPLY) ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (k == words_out && !iss_valid) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy       = state != S_IDLE;
    issue      = (state == S_SCAN && k < wcnt) || (state == S_OUT && k < words_out);
    lane_en    = state == S_SCAN && iss_valid;
    merge_load = state == S_SUM;
    out_load   = (state == S_DECIDE && status != ST_REPLY) || (state == S_OUT && iss_valid);
  end

  always_comb begin
    if (ovf) begin
      status = ST_LEN_BAD;
    end else if (len < MIN_FRAME) begin
      status = ST_SHORT;
    end else if (ether != ETHERTYPE_IPV4) begin
      status = ST_NOT_IPV4;
    end else if (hl < MIN_IHL_BYTES) begin
      status = ST_BAD_IHL;
    end else if (len < MIN_ICMP_OFS + LEN_W'(hl)) begin
      status = ST_SHORT_ICMP;
    end else if (proto != PROTO_ICMP) begin
      status = ST_NOT_ICMP;
    end else if (dst != local_ip) begin
      status = ST_WRONG_ADDR;
    end else if (icmp_type != ICMP_ECHO_REQ) begin
      status = ST_NOT_ECHO;
    end else if (tot < 16'(hl) || {1'b0, tot} + 17'(14) > 17'(len)) begin
      status = ST_LEN_BAD;
    end else begin
      status = ST_REPLY;
    end
  end

  assign lctrl.clr        = frame_end;
  assign lctrl.en         = lane_en;
  assign lctrl.icmp_start = icmp_start;
  assign lctrl.icmp_end   = {1'b0, tot} + 17'(14);

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    icer_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctrl (lctrl),
      .half (rd_data[(LANES-1-j)*16 +: 16]),
      .pos  ({1'b0, iss_k[ADDR_W-1:0], 2'(j), 1'b0}),
      .acc  (lsum[j])
    );
  end

  icer_merge u_merge (
    .clk       (clk),
    .load      (merge_load),
    .lanes     (lsum),
    .icmp_csum (csum_icmp),
    .ip_csum   (csum_ip)
  );

  always_comb begin
    for (int b = 0; b < HDR_WORDS * 8; b++) begin
      int src;
      src = b;
      if (b < 6) src = b + 6;
      else if (b < 12) src = b - 6;
      else if (b >= 26 && b < 30) src = b + 4;
      else if (b >= 30 && b < 34) src = b - 4;
      hsw[HDR_IDX_W'(b >> 3)][(7 - (b & 7)) * 8 +: 8] =
        hdr[HDR_IDX_W'(src >> 3)][(7 - (src & 7)) * 8 +: 8];
    end
  end

  always_comb begin
    base  = (iss_k < CNT_W'(HDR_WORDS)) ? hsw[iss_k[HDR_IDX_W-1:0]] : rd_data;
    reply = base;
    for (int j = 0; j < 8; j++) begin
      bpos = {1'b0, iss_k[ADDR_W-1:0], 3'(j)};
      if (bpos == icmp_start) reply[(7-j)*8 +: 8] = 8'd0;
      else if (bpos == icmp_start + CSUM_OFS) reply[(7-j)*8 +: 8] = csum_icmp[15:8];
      else if (bpos == icmp_start + CSUM_OFS_LO) reply[(7-j)*8 +: 8] = csum_icmp[7:0];
      else if (bpos == POS_IP_CSUM) reply[(7-j)*8 +: 8] = csum_ip[15:8];
      else if (bpos == POS_IP_CSUM_LO) reply[(7-j)*8 +: 8] = csum_ip[7:0];
      if (bpos >= len) reply[(7-j)*8 +: 8] = 8'd0;
    end
    reply_last  = iss_k == words_out - CNT_W'(1);
    reply_bytes = reply_last ? 4'(len - {1'b0, iss_k[ADDR_W-1:0], 3'b000}) : 4'd8;
  end

  always_ff @(posedge clk) begin
    if (state == S_DECIDE && status != ST_REPLY) begin
      out_data     <= '0;
      out_bytes    <= 4'd0;
      out_last     <= 1'b1;
      frame_status <= status;
    end else if (state == S_OUT && iss_valid) begin
      out_data     <= reply;
      out_bytes    <= reply_bytes;
      out_last     <= reply_last;
      frame_status <= ST_REPLY;
    end
  end

  `ASSERT_IMP(a_drop_single, out_valid && frame_status != ST_REPLY, out_last && out_bytes == 4'd0, "A drop status must be one empty beat.")
  `ASSERT_NXT(a_reply_burst, out_valid && !out_last, out_valid && frame_status == ST_REPLY, "Reply beats must be contiguous.")
  `ASSERT_NXT(a_end_busy, start && !busy && word_last, busy, "The block must go busy after a frame ends.")
  `ASSERT_IMP(a_count_range, 1'b1, word_count <= CNT_W'(FRAME_WORDS), "The word count ran past the store.")

endmodule

/* rtl/core/icer_lane.sv */
// One checksum lane: accumulates one 16-bit column of each scanned word.
`timescale 1ns / 1ps
module icer_lane (
  input  logic                     clk,
  input  logic                     rst,
  input  icer_pkg::lane_ctrl_t     ctrl,
  input  logic [15:0]              half,
  input  logic [icer_pkg::LEN_W-1:0] pos,
  output icer_pkg::lane_sum_t      acc
);
  import icer_pkg::*;

  logic [LEN_W-1:0] pos_lo;
  logic [7:0]       ip_hi, ip_lo, icmp_hi, icmp_lo;

  function automatic logic in_ip(input logic [LEN_W-1:0] b, input lane_ctrl_t c);
    return (b >= POS_IP_START) && (b < c.icmp_start) &&
           (b != POS_IP_CSUM) && (b != POS_IP_CSUM_LO);
  endfunction

  function automatic logic in_icmp(input logic [LEN_W-1:0] b, input lane_ctrl_t c);
    return (b >= c.icmp_start) && (17'(b) < c.icmp_end) && (b != c.icmp_start) &&
           (b != c.icmp_start + CSUM_OFS) && (b != c.icmp_start + CSUM_OFS_LO);
  endfunction

  always_comb begin
    pos_lo  = pos + LEN_W'(1);
    ip_hi   = in_ip(pos, ctrl) ? half[15:8] : 8'd0;
    ip_lo   = in_ip(pos_lo, ctrl) ? half[7:0] : 8'd0;
    icmp_hi = in_icmp(pos, ctrl) ? half[15:8] : 8'd0;
    icmp_lo = in_icmp(pos_lo, ctrl) ? half[7:0] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      acc <= '0;
    end else if (ctrl.en) begin
      acc.ip   <= acc.ip + ACC_W'({ip_hi, ip_lo});
      acc.icmp <= acc.icmp + ACC_W'({icmp_hi, icmp_lo});
    end
  end

endmodule

/* rtl/core/icer_merge.sv */
// Merge stage: adds the lane sums and folds them into the two checksums.
`timescale 1ns / 1ps
module icer_merge (
  input  logic                clk,
  input  logic                load,
  input  icer_pkg::lane_sum_t lanes [icer_pkg::LANES],
  output logic [15:0]         icmp_csum,
  output logic [15:0]         ip_csum
);
  import icer_pkg::*;

  logic [SUM_W-1:0] sum_icmp, sum_ip;
  logic [SUM_W-1:0] tot_icmp, tot_ip;

  function automatic logic [15:0] fold(input logic [SUM_W-1:0] s);
    logic [16:0] f1;
    logic [15:0] f2;
    f1 = {1'b0, s[15:0]} + 17'(s[SUM_W-1:16]);
    f2 = f1[15:0] + {15'd0, f1[16]};
    return ~f2;
  endfunction

  always_comb begin
    tot_icmp = '0;
    tot_ip   = '0;
    for (int i = 0; i < LANES; i++) begin
      tot_icmp = tot_icmp + SUM_W'(lanes[i].icmp);
      tot_ip   = tot_ip + SUM_W'(lanes[i].ip);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_icmp <= tot_icmp;
      sum_ip   <= tot_ip;
    end
  end

  assign icmp_csum = fold(sum_icmp);
  assign ip_csum   = fold(sum_ip);

endmodule

/* dv/icer_checker.sv */
// Checker for the ICMP echo responder: predicts every result beat and compares it.
`timescale 1ns / 1ps
module icer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] word_data,
  input  logic [3:0]  word_bytes,
  input  logic        word_last,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        out_valid,
  input  logic [63:0] out_data,
  input  logic [3:0]  out_bytes,
  input  logic        out_last,
  input  logic [3:0]  frame_status,
  output int          fail_count,
  output int          pending
);
  import icer_pkg::*;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
    logic [3:0]  status;
  } reply_beat_t;

  logic [63:0] frame_mem [FRAME_WORDS];
  int          words_held;
  int          frame_len;
  bit          too_long;
  logic [31:0] answer_ip;
  reply_beat_t reply_q [$];
  int          mismatches;

  function automatic logic [7:0] rd_byte(int p);
    if ((p >> 3) >= FRAME_WORDS) return 8'h00;
    return frame_mem[p >> 3][(7 - (p & 7)) * 8 +: 8];
  endfunction

  function automatic void wr_byte(int p, logic [7:0] v);
    if ((p >> 3) < FRAME_WORDS) frame_mem[p >> 3][(7 - (p & 7)) * 8 +: 8] = v;
  endfunction

  function automatic void swap_run(int a, int b, int n);
    logic [7:0] t;
    for (int i = 0; i < n; i++) begin
      t = rd_byte(a + i);
      wr_byte(a + i, rd_byte(b + i));
      wr_byte(b + i, t);
    end
  endfunction

  function automatic logic [15:0] inet_sum(int first, int n);
    logic [31:0] s;
    s = 0;
    for (int i = 0; i + 1 < n; i += 2) s += {rd_byte(first + i), rd_byte(first + i + 1)};
    if (n & 1) s += {rd_byte(first + n - 1), 8'h00};
    while (s >> 16) s = (s & 32'hFFFF) + (s >> 16);
    return ~s[15:0];
  endfunction

  function automatic logic [3:0] judge_frame(int len);
    int hl, icmp, tot;
    logic [15:0] c;
    if (too_long) return ST_LEN_BAD;
    if (len < 34) return ST_SHORT;
    if ({rd_byte(12), rd_byte(13)} != ETHERTYPE_IPV4) return ST_NOT_IPV4;
    hl = (rd_byte(14) & 8'h0F) * 4;
    if (hl < 20) return ST_BAD_IHL;
    if (len < 14 + hl + 8) return ST_SHORT_ICMP;
    if (rd_byte(23) != PROTO_ICMP) return ST_NOT_ICMP;
    if ({rd_byte(30), rd_byte(31), rd_byte(32), rd_byte(33)} != answer_ip)
      return ST_WRONG_ADDR;
    icmp = 14 + hl;
    if (rd_byte(icmp) != ICMP_ECHO_REQ) return ST_NOT_ECHO;
    tot = {rd_byte(16), rd_byte(17)};
    if (tot < hl || 14 + tot > len) return ST_LEN_BAD;
    swap_run(0, 6, 6);
    swap_run(26, 30, 4);
    wr_byte(icmp, 8'h00);
    wr_byte(icmp + 2, 8'h00);
    wr_byte(icmp + 3, 8'h00);
    c = inet_sum(icmp, tot - hl);
    wr_byte(icmp + 2, c[15:8]);
    wr_byte(icmp + 3, c[7:0]);
    wr_byte(24, 8'h00);
    wr_byte(25, 8'h00);
    c = inet_sum(14, hl);
    wr_byte(24, c[15:8]);
    wr_byte(25, c[7:0]);
    return ST_REPLY;
  endfunction

  function automatic void take_beat(logic [63:0] d, logic [3:0] nb_in, logic lst);
    int nb, len, nwords, cnt;
    logic [3:0] st;
    logic [63:0] w;
    nb = (nb_in > 8) ? 8 : nb_in;
    if (words_held < FRAME_WORDS) begin
      frame_mem[words_held] = d;
      words_held++;
      frame_len += lst ? nb : 8;
    end else begin
      too_long = 1;
    end
    if (!lst) return;
    len = frame_len;
    st = judge_frame(len);
    words_held = 0;
    frame_len = 0;
    too_long = 0;
    if (st != ST_REPLY) begin
      reply_q.push_back('{64'h0, 4'd0, 1'b1, st});
      return;
    end
    nwords = (len + 7) / 8;
    for (int k = 0; k < nwords; k++) begin
      cnt = (k + 1 == nwords) ? len - 8 * k : 8;
      w = frame_mem[k];
      if (cnt < 8) w &= ~((64'd1 << ((8 - cnt) * 8)) - 64'd1);
      reply_q.push_back('{w, 4'(cnt), k + 1 == nwords, ST_REPLY});
    end
  endfunction

  initial begin
    foreach (frame_mem[i]) frame_mem[i] = 64'h0;
    words_held = 0;
    frame_len = 0;
    too_long = 0;
    answer_ip = 32'h0;
    mismatches = 0;
  end

  always @(posedge clk) begin
    reply_beat_t e;
    if (rst) begin
      words_held = 0;
      frame_len = 0;
      too_long = 0;
      answer_ip = 32'h0;
    end else begin
      if (out_valid) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result beat data=%h bytes=%0d last=%0b status=%0d",
                     out_data, out_bytes, out_last, frame_status);
        end else begin
          e = reply_q.pop_front();
          if (out_data !== e.data || out_bytes !== e.nbytes || out_last !== e.last ||
              frame_status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result beat exp %h/%0d/%0b/%0d got %h/%0d/%0b/%0d",
                       e.data, e.nbytes, e.last, e.status,
                       out_data, out_bytes, out_last, frame_status);
          end
        end
      end
      if (cfg_wr_en) answer_ip = cfg_wr_data;
      if (start && !busy) take_beat(word_data, word_bytes, word_last);
    end
    fail_count = mismatches;
    pending = reply_q.size();
  end

endmodule

/* dv/tb.sv */
// Testbench top for the ICMP echo responder: frame stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb;
  import icer_pkg::*;

  typedef enum int {
    F_NONE, F_ETYPE, F_IHL, F_PROTO, F_ADDR, F_TYPE, F_TOT_LOW, F_TOT_HIGH
  } fault_t;
  typedef enum int {LM_EXACT, LM_OVER8, LM_ZERO} last_mode_t;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [63:0] word_data = 0;
  logic [3:0]  word_bytes = 0;
  logic        word_last = 0;
  logic        cfg_wr_en = 0;
  logic [31:0] cfg_wr_data = 0;
  logic        out_valid;
  logic [63:0] out_data;
  logic [3:0]  out_bytes;
  logic        out_last;
  logic [3:0]  frame_status;
  int          fail_count;
  int          pending;

  int          cycles = 0;
  int          gap_pct = 0;
  int          words_sent = 0;
  logic [31:0] cur_ip = 0;
  logic [7:0]  frame_buf [$];

  icmp_echo_responder_core uut (.*);
  icer_checker chk (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL icmp_echo_responder_core");
      $finish;
    end
  end

  task automatic set_ip(logic [31:0] ip);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_wr_en = 1;
    cfg_wr_data = ip;
    cur_ip = ip;
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  task automatic push_word(logic [63:0] d, logic [3:0] nb, logic lst);
    while ($urandom_range(99) < gap_pct) begin
      start = 0;
      @(negedge clk);
    end
    start = 1;
    word_data = d;
    word_bytes = nb;
    word_last = lst;
    do @(posedge clk); while (busy);
    words_sent++;
    @(negedge clk);
    start = 0;
  endtask

  task automatic send_frame(int len, int ihl, fault_t fault, last_mode_t lm, int trail);
    int hl, tot, n, cnt;
    logic [63:0] w;
    hl = ihl * 4;
    frame_buf.delete();
    for (int i = 0; i < ((len > 80) ? len : 80); i++) frame_buf.push_back(8'($urandom));
    frame_buf[12] = (fault == F_ETYPE) ? 8'($urandom_range(1, 255)) : 8'h08;
    frame_buf[13] = 8'h00;
    frame_buf[14] = {4'($urandom), (fault == F_IHL) ? 4'($urandom_range(0, 4)) : 4'(ihl)};
    tot = len - 14 - trail;
    if (fault == F_TOT_LOW) tot = $urandom_range(0, hl - 1);
    if (fault == F_TOT_HIGH) tot = $urandom_range(len - 13, (len - 13) + 3000);
    if ($urandom_range(9) == 0 && fault == F_TOT_HIGH) tot = 65535;
    frame_buf[16] = tot[15:8];
    frame_buf[17] = tot[7:0];
    frame_buf[23] = (fault == F_PROTO) ? 8'($urandom_range(2, 255)) : PROTO_ICMP;
    {frame_buf[30], frame_buf[31], frame_buf[32], frame_buf[33]} =
      (fault == F_ADDR) ? cur_ip ^ (32'd1 << $urandom_range(31)) : cur_ip;
    if (14 + hl < frame_buf.size())
      frame_buf[14 + hl] = (fault == F_TYPE) ? 8'($urandom_range(9, 255)) : ICMP_ECHO_REQ;
    n = (len + 7) / 8;
    for (int k = 0; k < n; k++) begin
      w = 0;
      for (int b = 0; b < 8; b++)
        w[(7 - b) * 8 +: 8] = (8 * k + b < len) ? frame_buf[8 * k + b] : 8'($urandom);
      cnt = len - 8 * k;
      if (k + 1 < n)
        push_word(w, 4'($urandom_range(0, 15)), 1'b0);
      else if (lm == LM_ZERO) begin
        push_word(w, 4'($urandom_range(0, 15)), 1'b0);
        push_word({$urandom, $urandom}, 4'd0, 1'b1);
      end else if (lm == LM_OVER8 && cnt == 8)
        push_word(w, 4'($urandom_range(9, 15)), 1'b1);
      else
        push_word(w, 4'(cnt), 1'b1);
    end
  endtask

  task automatic random_frame();
    int r, ihl, len, room;
    last_mode_t lm;
    r = $urandom_range(99);
    ihl = ($urandom_range(3) == 0) ? $urandom_range(6, 15) : 5;
    len = 14 + ihl * 4 + 8 + (($urandom_range(9) == 0) ? $urandom_range(0, 400) :
                                                          $urandom_range(0, 40));
    if (len > 512) len = 512;
    r = $urandom_range(9);
    lm = (r == 0) ? LM_OVER8 : (r == 1 && len <= 504) ? LM_ZERO : LM_EXACT;
    if (lm == LM_OVER8) len = (len + 7) / 8 * 8;
    room = len - 14 - ihl * 4;
    r = $urandom_range(99);
    if (r < 55)
      send_frame(len, ihl, F_NONE, lm, ($urandom_range(3) == 0) ? $urandom_range(0, room) : 0);
    else if (r < 85)
      send_frame(len, ihl, fault_t'($urandom_range(F_ETYPE, F_TOT_HIGH)), lm, 0);
    else if (r < 92)
      send_frame($urandom_range(1, 33), 5, F_NONE, LM_EXACT, 0);
    else if (r < 97) begin
      ihl = $urandom_range(6, 15);
      send_frame($urandom_range(34, 14 + ihl * 4 + 7), ihl, F_NONE, LM_EXACT, 0);
    end else
      send_frame($urandom_range(65 * 8 - 7, 66 * 8), 5, F_NONE, LM_EXACT, 0);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst = 0;
    set_ip(32'hC0A8_0001);
    send_frame(42, 5, F_NONE, LM_EXACT, 0);
    send_frame(43, 5, F_NONE, LM_EXACT, 0);
    send_frame(60, 5, F_NONE, LM_EXACT, 7);
    send_frame(14 + 60 + 8 + 5, 15, F_NONE, LM_EXACT, 0);
    send_frame(1, 5, F_NONE, LM_EXACT, 0);
    send_frame(33, 5, F_NONE, LM_EXACT, 0);
    send_frame(50, 5, F_ETYPE, LM_EXACT, 0);
    send_frame(50, 5, F_IHL, LM_EXACT, 0);
    send_frame(40, 8, F_NONE, LM_EXACT, 0);
    send_frame(50, 5, F_PROTO, LM_EXACT, 0);
    send_frame(50, 5, F_ADDR, LM_EXACT, 0);
    send_frame(50, 5, F_TYPE, LM_EXACT, 0);
    send_frame(50, 5, F_TOT_LOW, LM_EXACT, 0);
    send_frame(50, 5, F_TOT_HIGH, LM_EXACT, 0);
    send_frame(48, 5, F_NONE, LM_OVER8, 0);
    send_frame(48, 5, F_NONE, LM_ZERO, 0);
    send_frame(512, 5, F_NONE, LM_EXACT, 0);
    send_frame(520, 5, F_NONE, LM_EXACT, 0);
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 29 : (ph == 1) ? 57 : 0;
      set_ip((ph == 0) ? 32'hFFFF_FFFF : (ph == 1) ? 32'h0000_0000 : $urandom);
      words_sent = 0;
      while (words_sent < 55) begin
        random_frame();
      end
    end
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASS icmp_echo_responder_core");
    else
      $display("FAIL icmp_echo_responder_core");
    $finish;
  end

endmodule
